// ----- design/frame_rate_meter_and_limiter_unit_macros.svh -----
// Assertion macros for the frame rate meter.
// FRM_ASSERT_NOW: consequent must hold in the same cycle as the antecedent.
// FRM_ASSERT_NXT: consequent must hold one cycle after the antecedent.
`ifndef FRAME_RATE_METER_AND_LIMITER_UNIT_MACROS_SVH
`define FRAME_RATE_METER_AND_LIMITER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define FRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/frm_pkg.sv -----
package frm_pkg;

    localparam int WINDOW   = 10;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int FT_W     = 16;
    localparam int SUM_W    = FT_W + SLOT_W;
    localparam int RATE_W   = 18;
    localparam int TR_W     = 10;
    localparam int WAIT_W   = 10;
    localparam int TIME_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // shared divider: dividend wide enough for the window sum and the rate numerator
    localparam int DVD_W    = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int DSR_W    = FT_W;
    localparam int STEP_W   = $clog2(DVD_W);

    localparam logic [DVD_W-1:0] RATE_NUM  = DVD_W'(256000);
    localparam logic [DVD_W-1:0] MS_PER_S  = DVD_W'(1000);
    localparam logic [TR_W-1:0]  TR_RESET  = TR_W'(60);
    localparam logic [FT_W-1:0]  FT_MAX    = {FT_W{1'b1}};

    // register map; writes take the word index from paddr[2], reads decode the full paddr
    localparam logic REG_TARGET_RATE = 1'b0;
    localparam logic [ADDR_W-1:0] ADDR_TARGET_RATE = ADDR_W'(0);

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/frame_rate_meter_and_limiter_unit.sv -----
// Channel   Signals                                   Direction
// cfg       psel penable pwrite paddr pwdata prdata   APB write/read, pready tied high
// in        in_valid in_ready func time_ms            frame begin / frame end items
// out       out_valid out_ready frame_time ...        one item per frame end
//
// Frame begin: accepted with no result.
// Frame end: the sequencer walks the window sum, then makes up to three passes through the
// shared divider; the rate pass is skipped when the average frame time is zero.
// in_ready is high only when the sequencer is idle; a finished item waits in the
// output register, and the sequencer holds its last step while that is still full.
// Reset is asynchronous; the frame time ring is not cleared, only written entries are read.
`include "frame_rate_meter_and_limiter_unit_macros.svh"
module frame_rate_meter_and_limiter_unit
    import frm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [TIME_W-1:0] time_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FT_W-1:0]   frame_time,
    output logic [FT_W-1:0]   avg_frame_time,
    output logic [RATE_W-1:0] rate_q8,
    output logic [WAIT_W-1:0] wait_ms
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_ACC,
        S_AVG_GO,
        S_AVG_WAIT,
        S_RATE_GO,
        S_RATE_WAIT,
        S_Q_GO,
        S_Q_WAIT,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [TR_W-1:0]   target_reg;
    logic [TIME_W-1:0] start_time_reg;
    logic [TIME_W-1:0] last_end_reg;
    logic              seen_end_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  filled_reg;
    logic [RATE_W-1:0] rate_hold_reg;
    logic              out_valid_reg;

    logic [FT_W-1:0]   window_mem [WINDOW];
    logic [FT_W-1:0]   rd_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [FT_W-1:0]   ft_reg;
    logic [FT_W-1:0]   avg_reg;
    logic [TR_W-1:0]   q_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [FT_W-1:0]   ft_out_reg;
    logic [FT_W-1:0]   avg_out_reg;
    logic [RATE_W-1:0] rate_out_reg;
    logic [WAIT_W-1:0] wait_out_reg;

    logic              in_fire;
    logic              end_fire;
    logic              cfg_write;
    logic              out_room;
    logic [TIME_W-1:0] delta;
    logic [FT_W-1:0]   ft_next;
    logic [SLOT_W-1:0] slot_next;
    logic [CNT_W-1:0]  filled_next;
    logic [TR_W-1:0]   tr_eff;
    logic [WAIT_W-1:0] wait_next;
    logic [FT_W-1:0]   avg_next;

    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [DVD_W-1:0]  div_quo;

    frm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign end_fire  = in_fire && func;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_room  = !out_valid_reg || out_ready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_TARGET_RATE) ? DATA_W'(target_reg) : '0;

    always_comb
    begin
        delta       = time_ms - last_end_reg;
        if (!seen_end_reg)
            ft_next = '0;
        else if (delta > TIME_W'(FT_MAX))
            ft_next = FT_MAX;
        else
            ft_next = delta[FT_W-1:0];
        slot_next   = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
        filled_next = (filled_reg < CNT_W'(WINDOW)) ? filled_reg + 1'b1 : filled_reg;
        tr_eff      = (target_reg == '0) ? TR_W'(1) : target_reg;
        wait_next   = (elapsed_reg < TIME_W'(q_reg))
                    ? q_reg - elapsed_reg[WAIT_W-1:0] : '0;
        avg_next    = div_quo[FT_W-1:0];
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = MS_PER_S;
        div_req.divisor  = DSR_W'(tr_eff);
        case (state_reg)
            S_AVG_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(sum_reg);
                div_req.divisor  = DSR_W'(filled_reg);
            end
            S_RATE_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = RATE_NUM;
                div_req.divisor  = avg_reg;
            end
            S_Q_GO:
            begin
                div_req.start    = 1'b1;
            end
            default:
            begin
                div_req.start    = 1'b0;
            end
        endcase
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            target_reg     <= TR_RESET;
            start_time_reg <= '0;
            last_end_reg   <= '0;
            seen_end_reg   <= 1'b0;
            slot_reg       <= '0;
            filled_reg     <= '0;
            rate_hold_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write && paddr[2] == REG_TARGET_RATE)
                target_reg <= pwdata[TR_W-1:0];
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && !func)
                        start_time_reg <= time_ms;
                    if (end_fire)
                    begin
                        last_end_reg <= time_ms;
                        seen_end_reg <= 1'b1;
                        slot_reg     <= slot_next;
                        filled_reg   <= filled_next;
                        state_reg    <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_ACC;
                S_ACC:
                    state_reg <= (idx_reg + 1'b1 == filled_reg) ? S_AVG_GO : S_RD;
                S_AVG_GO:
                    state_reg <= S_AVG_WAIT;
                S_AVG_WAIT:
                begin
                    if (div_stat.done)
                        state_reg <= (avg_next != '0) ? S_RATE_GO : S_Q_GO;
                end
                S_RATE_GO:
                    state_reg <= S_RATE_WAIT;
                S_RATE_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        rate_hold_reg <= div_quo[RATE_W-1:0];
                        state_reg     <= S_Q_GO;
                    end
                end
                S_Q_GO:
                    state_reg <= S_Q_WAIT;
                S_Q_WAIT:
                begin
                    if (div_stat.done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_room)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // ring and datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (end_fire)
        begin
            window_mem[slot_reg] <= ft_next;
            ft_reg      <= ft_next;
            elapsed_reg <= time_ms - start_time_reg;
            sum_reg     <= '0;
            idx_reg     <= '0;
        end
        if (state_reg == S_RD)
            rd_reg <= window_mem[idx_reg[SLOT_W-1:0]];
        if (state_reg == S_ACC)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_reg);
            idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == S_AVG_WAIT && div_stat.done)
            avg_reg <= avg_next;
        if (state_reg == S_Q_WAIT && div_stat.done)
            q_reg <= div_quo[TR_W-1:0];
        if (state_reg == S_OUT && out_room)
        begin
            ft_out_reg   <= ft_reg;
            avg_out_reg  <= avg_reg;
            rate_out_reg <= rate_hold_reg;
            wait_out_reg <= wait_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_time     = ft_out_reg;
    assign avg_frame_time = avg_out_reg;
    assign rate_q8        = rate_out_reg;
    assign wait_ms        = wait_out_reg;

    `FRM_ASSERT_NXT(a_end_starts_walk, clk, rst_n, end_fire, state_reg == S_RD,
        "frame end did not start the window walk")
    `FRM_ASSERT_NOW(a_walk_in_range, clk, rst_n, state_reg == S_RD,
        filled_reg != '0 && idx_reg < filled_reg, "window walk index out of range")
    `FRM_ASSERT_NOW(a_div_done_expected, clk, rst_n, div_stat.done,
        state_reg == S_AVG_WAIT || state_reg == S_RATE_WAIT || state_reg == S_Q_WAIT,
        "divider finished outside a wait step")
    `FRM_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_req.start, !div_stat.busy,
        "divider started while busy")
    `FRM_ASSERT_NOW(a_slot_in_range, clk, rst_n, 1'b1,
        slot_reg < SLOT_W'(WINDOW) && filled_reg <= CNT_W'(WINDOW),
        "ring pointer or fill count out of range")
    `FRM_ASSERT_NOW(a_result_from_out_step, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == S_OUT, "result raised outside the output step")

endmodule

// ----- design/frm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module frm_div
    import frm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DVD_W-1:0]  quo_reg;

    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              fits;
    logic [DSR_W-1:0]  rem_next;
    logic [DVD_W-1:0]  quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = !diff[DSR_W];
        rem_next = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
